### src/gabp_pkg.sv
package gabp_pkg;

  // Number of register stages from input transaction to output register.
  localparam int STAGES = 7;

  localparam logic [8:0]  OPACITY_ONE = 9'd256;
  localparam logic [15:0] FULL_WEIGHT = 16'd65280;
  // floor(2^24 / 255), used to divide by 255 with a single correction step.
  localparam logic [16:0] RECIP_255   = 17'd65793;
  localparam logic [23:0] DIV_255     = 24'd255;

  // Configuration register indexes.
  localparam logic REG_OPACITY    = 1'b0;
  localparam logic REG_BACK_ALPHA = 1'b1;

  typedef logic [STAGES-1:0] stage_en_t;

  typedef struct packed {
    logic [7:0] overlay_red;
    logic [7:0] overlay_green;
    logic [7:0] overlay_blue;
    logic [7:0] overlay_alpha;
    logic [7:0] back_red;
    logic [7:0] back_green;
    logic [7:0] back_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blend_red;
    logic [7:0] blend_green;
    logic [7:0] blend_blue;
    logic [7:0] blend_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } sqrt_state_t;

  // One digit of the restoring square root: brings in two bits of the radicand.
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [1:0] pair);
    logic [11:0] cur;
    logic [11:0] trial;
    sqrt_state_t r;
    cur   = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = 10'(cur - trial);
      r.root = {s.root[6:0], 1'b1};
    end else begin
      r.rem  = cur[9:0];
      r.root = {s.root[6:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### src/gabp_weight.sv
module gabp_weight (
  input  logic                 clk,
  input  logic                 en,
  input  logic [8:0]           opacity_q8,
  input  logic [7:0]           alpha,
  output logic [15:0]          w,
  output logic [15:0]          w_inv
);

  logic [8:0]  op;
  logic [16:0] prod;

  always_comb begin
    op   = (opacity_q8 > gabp_pkg::OPACITY_ONE) ? gabp_pkg::OPACITY_ONE : opacity_q8;
    prod = 17'(alpha) * 17'(op);
  end

  // The product never exceeds 255 * 256, so it fits in 16 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      w     <= prod[15:0];
      w_inv <= gabp_pkg::FULL_WEIGHT - prod[15:0];
    end
  end

endmodule

### src/gabp_sqrt.sv
module gabp_sqrt (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [15:0] q,
  output logic [7:0]  root
);

  gabp_pkg::sqrt_state_t s0;
  gabp_pkg::sqrt_state_t s1;
  gabp_pkg::sqrt_state_t hi;
  gabp_pkg::sqrt_state_t lo;
  logic [7:0]            low_bits;

  always_comb begin
    s0 = '0;
    for (int i = 3; i >= 0; i--) begin
      s0 = gabp_pkg::sqrt_step(s0, q[8 + 2*i +: 2]);
    end
    s1 = hi;
    for (int i = 3; i >= 0; i--) begin
      s1 = gabp_pkg::sqrt_step(s1, low_bits[2*i +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hi       <= s0;
      low_bits <= q[7:0];
    end
    if (en[1]) begin
      lo <= s1;
    end
  end

  assign root = lo.root;

endmodule

### src/gabp_channel.sv
module gabp_channel (
  input  logic                  clk,
  input  gabp_pkg::stage_en_t   en,
  input  logic [7:0]            ov,
  input  logic [7:0]            bg,
  input  logic [15:0]           w,
  input  logic [15:0]           w_inv,
  output logic [7:0]            result
);

  logic [15:0] sq_ov;
  logic [15:0] sq_bg;
  logic [31:0] p_ov;
  logic [31:0] p_bg;
  logic [23:0] s_div;
  logic [23:0] s_div_d;
  logic [15:0] est;
  logic [15:0] q;

  logic [31:0] sum;
  logic [40:0] recip_prod;
  logic [23:0] rem;

  always_comb begin
    sum        = p_ov + p_bg;
    recip_prod = 41'(s_div) * 41'(gabp_pkg::RECIP_255);
    rem        = s_div_d - ({est, 8'd0} - 24'(est));
  end

  // Division by 65280 is a shift by 8 followed by division by 255. The
  // reciprocal estimate is low by at most one, which the remainder fixes.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_ov <= 16'(ov) * 16'(ov);
      sq_bg <= 16'(bg) * 16'(bg);
    end
    if (en[1]) begin
      p_ov <= 32'(sq_ov) * 32'(w);
      p_bg <= 32'(sq_bg) * 32'(w_inv);
    end
    if (en[2]) begin
      s_div <= sum[31:8];
    end
    if (en[3]) begin
      est     <= recip_prod[39:24];
      s_div_d <= s_div;
    end
    if (en[4]) begin
      q <= (rem >= gabp_pkg::DIV_255) ? est + 16'd1 : est;
    end
  end

  gabp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[6:5]),
    .q    (q),
    .root (result)
  );

endmodule

### src/gamma_alpha_blend_pixel.sv
// Gamma-correct alpha blend of one overlay RGBA pixel onto one RGB background
// pixel, blending each color channel in squared space and taking the integer
// square root of the result.
// The input channel carries one pixel pair per transaction (in_valid/in_ready,
// in_data); the output channel returns one blended pixel per transaction
// (out_valid/out_ready, out_data). Every input gives exactly one output.
// With out_ready held high, throughput is one pixel per clock. The pipeline
// has seven register stages: weight and squares, the two weighted products,
// their sum, the reciprocal multiply for the divide by 255, the remainder
// correction, and two stages of four square-root digits each.
// The configuration port writes opacity_q8 (index 0) and background_has_alpha
// (index 1) on any cycle with cfg_write high; change them only while the
// pipeline is empty. Reset empties the pipeline and sets opacity to 1.0 and
// background alpha off.
// When the receiver stalls, each stage holds its pixel; bubbles close up and
// in_ready drops only once every stage is full.
module gamma_alpha_blend_pixel (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gabp_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gabp_pkg::pix_out_t out_data,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);

  logic [8:0]          opacity_q8;
  logic                back_alpha;
  logic [gabp_pkg::STAGES-1:0] vld;
  gabp_pkg::stage_en_t en;
  logic [15:0]         w;
  logic [15:0]         w_inv;
  logic [7:0]          res_r;
  logic [7:0]          res_g;
  logic [7:0]          res_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity_q8 <= gabp_pkg::OPACITY_ONE;
      back_alpha <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gabp_pkg::REG_OPACITY:    opacity_q8 <= cfg_data;
        gabp_pkg::REG_BACK_ALPHA: back_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[gabp_pkg::STAGES-1] = !vld[gabp_pkg::STAGES-1] || out_ready;
    for (int k = gabp_pkg::STAGES-2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < gabp_pkg::STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  gabp_weight u_weight (
    .clk        (clk),
    .en         (en[0]),
    .opacity_q8 (opacity_q8),
    .alpha      (in_data.overlay_alpha),
    .w          (w),
    .w_inv      (w_inv)
  );

  gabp_channel u_red (
    .clk    (clk),
    .en     (en),
    .ov     (in_data.overlay_red),
    .bg     (in_data.back_red),
    .w      (w),
    .w_inv  (w_inv),
    .result (res_r)
  );

  gabp_channel u_green (
    .clk    (clk),
    .en     (en),
    .ov     (in_data.overlay_green),
    .bg     (in_data.back_green),
    .w      (w),
    .w_inv  (w_inv),
    .result (res_g)
  );

  gabp_channel u_blue (
    .clk    (clk),
    .en     (en),
    .ov     (in_data.overlay_blue),
    .bg     (in_data.back_blue),
    .w      (w),
    .w_inv  (w_inv),
    .result (res_b)
  );

  assign in_ready  = en[0];
  assign out_valid = vld[gabp_pkg::STAGES-1];

  always_comb begin
    out_data.blend_red   = res_r;
    out_data.blend_green = res_g;
    out_data.blend_blue  = res_b;
    out_data.blend_alpha = back_alpha ? 8'd255 : 8'd0;
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  gabp_pkg::pix_in_t   in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  gabp_pkg::pix_out_t  out_data;
  logic                cfg_write = 1'b0;
  logic                cfg_index = gabp_pkg::REG_OPACITY;
  logic [8:0]          cfg_data = '0;

  // Pixels waiting to be driven and blends waiting to come out.
  gabp_pkg::pix_in_t  pix_q[$];
  gabp_pkg::pix_out_t blend_q[$];

  // Copy of the configuration as the block sees it.
  logic [8:0] opacity_shadow;
  logic       back_alpha_shadow;

  int send_idle_pct = 18;
  int recv_stall_pct = 68;
  int mismatches = 0;

  gabp_pkg::pix_out_t want_pix;

  gamma_alpha_blend_pixel dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One color channel blended in squared space, then the floor of the square root.
  function automatic logic [7:0] mix_channel(logic [7:0] ov, logic [7:0] bg,
                                             logic [15:0] w);
    logic [33:0] acc;
    logic [15:0] q;
    logic [7:0]  root;
    acc = 34'(ov) * 34'(ov) * 34'(w) +
          34'(bg) * 34'(bg) * 34'(gabp_pkg::FULL_WEIGHT - w);
    q = 16'(acc / 34'(gabp_pkg::FULL_WEIGHT));
    root = '0;
    for (int b = 7; b >= 0; b--) begin
      root[b] = 1'b1;
      if (17'(root) * 17'(root) > 17'(q)) root[b] = 1'b0;
    end
    return root;
  endfunction

  function automatic gabp_pkg::pix_out_t blend_pixel(gabp_pkg::pix_in_t p,
                                                     logic [8:0] opacity,
                                                     logic back_alpha);
    logic [8:0]         op;
    logic [15:0]        w;
    gabp_pkg::pix_out_t r;
    op = (opacity > gabp_pkg::OPACITY_ONE) ? gabp_pkg::OPACITY_ONE : opacity;
    w = 16'(p.overlay_alpha) * 16'(op);
    r.blend_red   = mix_channel(p.overlay_red, p.back_red, w);
    r.blend_green = mix_channel(p.overlay_green, p.back_green, w);
    r.blend_blue  = mix_channel(p.overlay_blue, p.back_blue, w);
    r.blend_alpha = back_alpha ? 8'hFF : 8'h00;
    return r;
  endfunction

  function automatic gabp_pkg::pix_in_t mk_pix(logic [7:0] ovr, logic [7:0] ovg,
                                               logic [7:0] ovb, logic [7:0] ova,
                                               logic [7:0] bgr, logic [7:0] bgg,
                                               logic [7:0] bgb);
    gabp_pkg::pix_in_t p;
    p.overlay_red   = ovr;
    p.overlay_green = ovg;
    p.overlay_blue  = ovb;
    p.overlay_alpha = ova;
    p.back_red      = bgr;
    p.back_green    = bgg;
    p.back_blue     = bgb;
    return p;
  endfunction

  // Appends one pixel to the tail of the pending queue.
  function automatic void queue_pix(gabp_pkg::pix_in_t p);
    pix_q.insert(pix_q.size(), p);
  endfunction

  // Mostly uniform, with the two extremes picked more often than chance.
  function automatic logic [7:0] rand_chan(int extreme_odds);
    if ($urandom_range(extreme_odds) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pix_q.size() != 0 || in_valid || blend_q.size() != 0) @(negedge clk);
    repeat (gabp_pkg::STAGES + 2) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      opacity_shadow    <= gabp_pkg::OPACITY_ONE;
      back_alpha_shadow <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == gabp_pkg::REG_OPACITY) opacity_shadow <= cfg_data;
      else back_alpha_shadow <= cfg_data[0];
    end
  end

  // Driver: the prediction is made when the transaction is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        blend_q.insert(blend_q.size(),
                       blend_pixel(in_data, opacity_shadow, back_alpha_shadow));
      if (!in_valid || in_ready) begin
        if (pix_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pix_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (blend_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output transaction %h", out_data);
        end else begin
          want_pix = blend_q.pop_front();
          if (out_data.blend_red !== want_pix.blend_red ||
              out_data.blend_green !== want_pix.blend_green ||
              out_data.blend_blue !== want_pix.blend_blue ||
              out_data.blend_alpha !== want_pix.blend_alpha) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"blend mismatch: expected r=%0d g=%0d b=%0d a=%0d, ",
                        "got r=%0d g=%0d b=%0d a=%0d"},
                       want_pix.blend_red, want_pix.blend_green, want_pix.blend_blue,
                       want_pix.blend_alpha, out_data.blend_red, out_data.blend_green,
                       out_data.blend_blue, out_data.blend_alpha);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [8:0] opac_set [8];
    logic       alpha_set [8];
    opac_set  = '{9'd0, 9'd511, 9'd257, 9'd128, 9'd1, 9'd255, 9'd0, 9'd256};
    alpha_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    opac_set[6]  = 9'($urandom_range(511));
    alpha_set[6] = 1'($urandom_range(1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pixels under the reset configuration.
    queue_pix(mk_pix(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    queue_pix(mk_pix(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_pix(mk_pix(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    queue_pix(mk_pix(8'hFF, 8'h00, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h80));
    queue_pix(mk_pix(8'h12, 8'h34, 8'h56, 8'h01, 8'hAB, 8'hCD, 8'hEF));
    queue_pix(mk_pix(8'h12, 8'h34, 8'h56, 8'hFE, 8'hAB, 8'hCD, 8'hEF));
    queue_pix(mk_pix(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55));
    queue_pix(mk_pix(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA));
    queue_pix(mk_pix(8'h01, 8'h02, 8'h04, 8'h7F, 8'h08, 8'h10, 8'h20));
    queue_pix(mk_pix(8'h80, 8'h40, 8'h20, 8'hC0, 8'hFE, 8'hFD, 8'hFB));
    queue_pix(mk_pix(8'h77, 8'h77, 8'h77, 8'h99, 8'h77, 8'h77, 8'h77));
    queue_pix(mk_pix(8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct  = 18;
        recv_stall_pct = 68;
      end else if (ph < 6) begin
        send_idle_pct  = 68;
        recv_stall_pct = 18;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      // The pipeline is empty here, so the registers may change.
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= gabp_pkg::REG_OPACITY;
      cfg_data  <= opac_set[ph];
      @(posedge clk);
      cfg_index <= gabp_pkg::REG_BACK_ALPHA;
      cfg_data  <= {8'h00, alpha_set[ph]};
      @(posedge clk);
      cfg_write <= 1'b0;
      @(negedge clk);

      queue_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
      queue_pix(mk_pix(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_pix(mk_pix(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h00));
      queue_pix(mk_pix(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
      for (int i = 0; i < 150; i++)
        queue_pix(mk_pix(rand_chan(7), rand_chan(7), rand_chan(7), rand_chan(3),
                         rand_chan(7), rand_chan(7), rand_chan(7)));
      wait_drained();
    end

    repeat (4 * gabp_pkg::STAGES) @(posedge clk);
    if (mismatches == 0 && blend_q.size() == 0) begin
      $display("[gamma_alpha_blend_pixel] OK");
    end else begin
      $display("[gamma_alpha_blend_pixel] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[gamma_alpha_blend_pixel] ERROR");
    $finish;
  end

endmodule

### files.f
src/gabp_pkg.sv
src/gabp_weight.sv
src/gabp_sqrt.sv
src/gabp_channel.sv
src/gamma_alpha_blend_pixel.sv
dv/tb_top.sv
